FILE: rtl/core/ncrd_pkg.sv
// Shared types and constants of the numeric character reference decoder.
package ncrd_pkg;

    localparam int unsigned MAX_PENDING_DEF = 16;

    localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;

    localparam logic [31:0] MASK_ONE   = 32'hFFFFFF80;
    localparam logic [31:0] MASK_TWO   = 32'hFFFFF800;
    localparam logic [31:0] MASK_THREE = 32'hFFFF0000;
    localparam logic [31:0] MASK_LOW6  = 32'h0000003F;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    // Source of the byte loaded into the result register.
    typedef enum logic [1:0] {
        SRC_IN,
        SRC_RBYTE,
        SRC_MEM,
        SRC_ENC
    } t_src;

    typedef struct packed {
        logic capture;
        logic keep;
        logic acc_en;
        logic acc_hex;
        logic clear;
        logic restart_amp;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic load;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic in_amp;
        logic in_hash;
        logic in_x;
        logic in_dec;
        logic in_hex;
        logic in_semi;
        logic in_zero;
        logic full;
        logic rb_amp;
        logic rb_zero;
        logic out_free;
        logic rpl_last;
        logic enc_last;
    } t_sts;

endpackage

FILE: rtl/core/numeric_char_reference_decoder_core.sv
// Top level of the numeric character reference decoder.
// A pass-through byte goes through the result register before it shows on the master side.
// Throughput: one byte per cycle for text and reference bytes while the master side takes
// them; a closing semicolon then emits its UTF-8 bytes one at a time, and a replay sends every
// pending byte via a store read and the result register, then a stopping byte but & or NUL.
// Reset: synchronous, active low; all control state clears, the pending store is left as is.
module numeric_char_reference_decoder_core #(
    parameter int unsigned MAX_PENDING = ncrd_pkg::MAX_PENDING_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,
    output logic       o_m_axis_tuser    // [0] error
);
    import ncrd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller owns the parser mode and the output sequencing; input
    // transactions are only taken while it waits for a new byte, and each
    // decision is made from the classified input byte in the same cycle.
    ncrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the bytes of the reference seen so far, the code
    // point accumulator with its overflow flag, the UTF-8 encoder and the
    // result register that parts the two sides of the block.
    ncrd_dpath #(
        .MAX_PENDING (MAX_PENDING)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .o_out_err   (o_m_axis_tuser)
    );

endmodule

FILE: rtl/core/ncrd_ctrl.sv
// Sequencing state machine of the numeric character reference decoder.
module ncrd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ncrd_pkg::t_sts i_sts,
    output ncrd_pkg::t_cmd o_cmd
);
    import ncrd_pkg::*;

    typedef enum logic [2:0] {
        ST_INPUT,
        ST_READ,
        ST_REPLAY,
        ST_PASS,
        ST_ENC
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_AMP,
        M_DEC_START,
        M_DEC,
        M_HEX_START,
        M_HEX
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    t_cmd   cmd;
    logic   accept;
    logic   rpl;

    assign o_ready = (r_state == ST_INPUT);
    assign accept  = o_ready && i_valid;
    assign o_cmd   = cmd;

    always_comb begin
        cmd     = '0;
        cmd.src = SRC_IN;
        n_state = r_state;
        n_mode  = r_mode;
        rpl     = 1'b0;
        unique case (r_state)
            ST_INPUT: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    unique case (r_mode) inside
                        M_IDLE: begin
                            if (i_sts.in_amp) begin
                                cmd.keep = 1'b1;
                                n_mode   = M_AMP;
                            end else if (!i_sts.in_zero) begin
                                if (i_sts.out_free) begin
                                    cmd.load = 1'b1;
                                    cmd.src  = SRC_IN;
                                    cmd.last = 1'b1;
                                end else begin
                                    n_state = ST_PASS;
                                end
                            end
                        end
                        M_AMP: begin
                            if (i_sts.in_hash) begin
                                cmd.keep = 1'b1;
                                n_mode   = M_DEC_START;
                            end else begin
                                rpl = 1'b1;
                            end
                        end
                        M_DEC_START, M_DEC: begin
                            if (r_mode == M_DEC_START && i_sts.in_x) begin
                                cmd.keep = 1'b1;
                                n_mode   = M_HEX_START;
                            end else if (i_sts.in_dec && !i_sts.full) begin
                                cmd.keep   = 1'b1;
                                cmd.acc_en = 1'b1;
                                n_mode     = M_DEC;
                            end else if (i_sts.in_semi && r_mode == M_DEC) begin
                                cmd.idx_clr = 1'b1;
                                n_state     = ST_ENC;
                            end else begin
                                rpl = 1'b1;
                            end
                        end
                        M_HEX_START, M_HEX: begin
                            if (i_sts.in_hex && !i_sts.full) begin
                                cmd.keep    = 1'b1;
                                cmd.acc_en  = 1'b1;
                                cmd.acc_hex = 1'b1;
                                n_mode      = M_HEX;
                            end else if (i_sts.in_semi && r_mode == M_HEX) begin
                                cmd.idx_clr = 1'b1;
                                n_state     = ST_ENC;
                            end else begin
                                rpl = 1'b1;
                            end
                        end
                        default: begin
                            cmd.clear = 1'b1;
                            n_mode    = M_IDLE;
                        end
                    endcase
                    if (rpl) begin
                        cmd.idx_clr = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd  = 1'b1;
                n_state = ST_REPLAY;
            end
            ST_REPLAY: begin
                if (i_sts.out_free) begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_MEM;
                    cmd.last = i_sts.rpl_last && (i_sts.rb_amp || i_sts.rb_zero);
                    if (i_sts.rpl_last) begin
                        if (i_sts.rb_amp) begin
                            cmd.restart_amp = 1'b1;
                            n_mode          = M_AMP;
                            n_state         = ST_INPUT;
                        end else begin
                            cmd.clear = 1'b1;
                            n_mode    = M_IDLE;
                            n_state   = i_sts.rb_zero ? ST_INPUT : ST_PASS;
                        end
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_PASS: begin
                if (i_sts.out_free) begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_RBYTE;
                    cmd.last = 1'b1;
                    n_state  = ST_INPUT;
                end
            end
            ST_ENC: begin
                if (i_sts.out_free) begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_ENC;
                    cmd.last = i_sts.enc_last;
                    if (i_sts.enc_last) begin
                        cmd.clear = 1'b1;
                        n_mode    = M_IDLE;
                        n_state   = ST_INPUT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_INPUT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INPUT;
            r_mode  <= M_IDLE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // An encode sequence only starts from inside a closed reference.
    a_enc_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENC) |-> (r_mode == M_DEC || r_mode == M_HEX))
        else $error("encode sequence outside a numeric reference");

    // The verbatim byte path is only used once the parser is back outside a reference.
    a_pass_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> (r_mode == M_IDLE))
        else $error("pass-through pending while inside a reference");

    // A replay never starts from the idle mode, where nothing is pending.
    a_rpl_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INPUT && n_state == ST_READ) |-> (r_mode != M_IDLE))
        else $error("replay requested with nothing pending");

endmodule

FILE: rtl/core/ncrd_dpath.sv
// Datapath of the numeric character reference decoder: pending store, accumulator, encoder.
module ncrd_dpath #(
    parameter int unsigned MAX_PENDING = ncrd_pkg::MAX_PENDING_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data,
    input  logic           i_out_ready,
    input  ncrd_pkg::t_cmd i_cmd,
    output ncrd_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [7:0]     o_out_data,
    output logic           o_out_last,
    output logic           o_out_err
);
    import ncrd_pkg::*;

    localparam int unsigned AW = $clog2(MAX_PENDING);
    localparam int unsigned CW = $clog2(MAX_PENDING + 1);

    logic [7:0]    r_mem [MAX_PENDING];
    logic [7:0]    r_rd;
    logic [7:0]    r_byte;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [20:0]   r_acc;
    logic          r_big;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_last;
    logic          r_out_err;

    logic [3:0]  digit;
    logic        is_dec;
    logic        is_hex;
    logic [24:0] acc_next;
    logic        out_free;
    logic        enc_err;
    logic [1:0]  enc_nm1;
    logic [7:0]  enc_byte;
    logic [31:0] acc_w;

    assign is_dec = (i_data >= CH_0) && (i_data <= CH_9);

    always_comb begin
        is_hex = 1'b1;
        digit  = '0;
        if (is_dec) begin
            digit = 4'(i_data - CH_0);
        end else if (i_data >= CH_A_UP && i_data <= CH_F_UP) begin
            digit = 4'(i_data - CH_A_UP + 8'd10);
        end else if (i_data >= CH_A_LO && i_data <= CH_F_LO) begin
            digit = 4'(i_data - CH_A_LO + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Times ten as a shift-add, times sixteen as a shift.
    assign acc_next = i_cmd.acc_hex ? ({r_acc, 4'b0000} + {21'd0, digit})
                                    : ({1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                                       + {21'd0, digit});

    assign out_free = !r_out_valid || i_out_ready;

    // UTF-8 encoder over the accumulated code point.
    assign acc_w   = {11'd0, r_acc};
    assign enc_err = r_big || (r_acc > CODE_LIMIT);

    always_comb begin
        if (enc_err || (acc_w & MASK_ONE) == '0) begin
            enc_nm1 = 2'd0;
        end else if ((acc_w & MASK_TWO) == '0) begin
            enc_nm1 = 2'd1;
        end else if ((acc_w & MASK_THREE) == '0) begin
            enc_nm1 = 2'd2;
        end else begin
            enc_nm1 = 2'd3;
        end
    end

    always_comb begin
        enc_byte = '0;
        if (!enc_err) begin
            case (enc_nm1)
                2'd0: enc_byte = r_acc[7:0];
                2'd1: begin
                    case (r_idx[1:0])
                        2'd0:    enc_byte = LEAD_TWO | {3'b000, r_acc[10:6]};
                        default: enc_byte = CONT_BYTE | 8'(acc_w & MASK_LOW6);
                    endcase
                end
                2'd2: begin
                    case (r_idx[1:0])
                        2'd0:    enc_byte = LEAD_THREE | {4'b0000, r_acc[15:12]};
                        2'd1:    enc_byte = CONT_BYTE | {2'b00, r_acc[11:6]};
                        default: enc_byte = CONT_BYTE | 8'(acc_w & MASK_LOW6);
                    endcase
                end
                default: begin
                    case (r_idx[1:0])
                        2'd0:    enc_byte = LEAD_FOUR | {5'b00000, r_acc[20:18]};
                        2'd1:    enc_byte = CONT_BYTE | {2'b00, r_acc[17:12]};
                        2'd2:    enc_byte = CONT_BYTE | {2'b00, r_acc[11:6]};
                        default: enc_byte = CONT_BYTE | 8'(acc_w & MASK_LOW6);
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        o_sts.in_amp   = (i_data == CH_AMP);
        o_sts.in_hash  = (i_data == CH_HASH);
        o_sts.in_x     = (i_data == CH_X_LO) || (i_data == CH_X_UP);
        o_sts.in_dec   = is_dec;
        o_sts.in_hex   = is_hex;
        o_sts.in_semi  = (i_data == CH_SEMI);
        o_sts.in_zero  = (i_data == CH_NUL);
        o_sts.full     = (r_count == CW'(MAX_PENDING));
        o_sts.rb_amp   = (r_byte == CH_AMP);
        o_sts.rb_zero  = (r_byte == CH_NUL);
        o_sts.out_free = out_free;
        o_sts.rpl_last = ((r_idx + CW'(1)) == r_count);
        o_sts.enc_last = (r_idx[1:0] == enc_nm1);
    end

    // Pending store, written at the fill position and read one entry at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.keep) begin
            r_mem[r_count[AW-1:0]] <= i_data;
        end else if (i_cmd.restart_amp) begin
            r_mem[AW'(0)] <= r_byte;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_data;
        end
        if (i_cmd.load) begin
            case (i_cmd.src)
                SRC_IN:    r_out_data <= i_data;
                SRC_RBYTE: r_out_data <= r_byte;
                SRC_MEM:   r_out_data <= r_rd;
                default:   r_out_data <= enc_byte;
            endcase
            r_out_last <= i_cmd.last;
            r_out_err  <= (i_cmd.src == SRC_ENC) && enc_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_big       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_acc   <= '0;
                r_big   <= 1'b0;
            end else if (i_cmd.restart_amp) begin
                r_count <= CW'(1);
                r_acc   <= '0;
                r_big   <= 1'b0;
            end else begin
                if (i_cmd.keep) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.acc_en && !r_big) begin
                    if (acc_next > {4'd0, CODE_LIMIT}) begin
                        r_big <= 1'b1;
                    end else begin
                        r_acc <= acc_next[20:0];
                    end
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_err   = r_out_err;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PENDING))
        else $error("pending count beyond store depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> out_free)
        else $error("result register loaded while still holding a result");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_data == 8'd0 && r_out_last))
        else $error("error result carries data or is not final");

endmodule

FILE: tb/numeric_char_reference_decoder_core_test.sv
// Self-checking testbench for the numeric character reference decoder core.
`timescale 1ns / 1ps

module numeric_char_reference_decoder_core_test;

    import ncrd_pkg::*;

    localparam int unsigned REF_DEPTH       = MAX_PENDING_DEF;
    localparam int          RANDOM_ITEMS    = 390;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          LONG_HOLD       = 300;
    localparam int          HOLD_FIRST_ITEM = 150;
    localparam int          HOLD_LAST_ITEM  = 230;

    // Where the decoder stands within a reference.
    typedef enum logic [2:0] {
        AT_TEXT,
        AT_AMP,
        AT_DEC_FIRST,
        AT_DEC,
        AT_HEX_FIRST,
        AT_HEX
    } t_ref_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_utf8_out;

    // A directed row either relies on the predictor or carries its result typed in.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       typed;
        logic [1:0] typed_n;
        logic [7:0] typed_data;
        logic       typed_err;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_byte
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;           // [0] error

    // Predictor state, mirroring the parser of the block.
    t_ref_mode   ref_mode = AT_TEXT;
    logic [20:0] ref_value = '0;
    logic        ref_overflow = 1'b0;
    logic [7:0]  ref_held [REF_DEPTH];
    int          ref_len = 0;

    t_utf8_out   decoded_now [$];
    t_utf8_out   decoded_due [$];
    t_stim_row   directed_rows [$];
    logic [7:0]  text_bytes [$];

    int          fail_count = 0;
    int          results_seen = 0;
    int          stalled_cycles = 0;
    logic        long_hold_req = 1'b0;
    t_utf8_out   want;

    numeric_char_reference_decoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------

    function automatic void put_text(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic void put_due(input t_utf8_out r);
        decoded_due.insert(decoded_due.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void emit_byte(input logic [7:0] b, input logic err);
        t_utf8_out r;
        r.data  = b;
        r.last  = 1'b0;
        r.error = err;
        decoded_now.insert(decoded_now.size(), r);
    endfunction

    function automatic void clear_reference();
        ref_mode     = AT_TEXT;
        ref_value    = '0;
        ref_overflow = 1'b0;
        ref_len      = 0;
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (ref_len < REF_DEPTH) begin
            ref_held[ref_len] = b;
            ref_len++;
        end
    endfunction

    // An unclosed reference is given back exactly as it came in.
    function automatic void replay_reference();
        for (int i = 0; i < ref_len; i++) begin
            emit_byte(ref_held[i], 1'b0);
        end
        clear_reference();
    endfunction

    function automatic void encode_reference();
        logic [31:0] cp;
        cp = {11'd0, ref_value};
        if (ref_overflow || cp > {11'd0, CODE_LIMIT}) begin
            emit_byte(8'h00, 1'b1);
        end else if ((cp & MASK_ONE) == 0) begin
            emit_byte(cp[7:0], 1'b0);
        end else if ((cp & MASK_TWO) == 0) begin
            emit_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b0);
        end else if ((cp & MASK_THREE) == 0) begin
            emit_byte(LEAD_THREE | {4'b0000, cp[15:12]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[11:6]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b0);
        end else begin
            // The full three-bit lead field is kept for four-byte sequences.
            emit_byte(LEAD_FOUR | {5'b00000, cp[20:18]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[17:12]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[11:6]}, 1'b0);
            emit_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b0);
        end
        clear_reference();
    endfunction

    // Returns 1 when the store was full, so the digit has to be handled again.
    function automatic logic take_digit(input logic [7:0] b, input logic [3:0] digit,
                                        input logic hex, input t_ref_mode next_mode);
        logic [31:0] v;
        if (ref_len >= REF_DEPTH) begin
            replay_reference();
            return 1'b1;
        end
        hold_byte(b);
        if (!ref_overflow) begin
            v = {11'd0, ref_value} * (hex ? 32'd16 : 32'd10) + {28'd0, digit};
            if (v > {11'd0, CODE_LIMIT}) begin
                ref_overflow = 1'b1;
            end else begin
                ref_value = v[20:0];
            end
        end
        ref_mode = next_mode;
        return 1'b0;
    endfunction

    // Works out every output byte that one accepted input byte causes.
    function automatic void decode_byte(input logic [7:0] b);
        logic       again;
        logic       is_dec;
        logic       is_hex;
        logic [7:0] hv;
        int         pass;
        decoded_now.delete();
        is_dec = (b >= CH_0 && b <= CH_9);
        is_hex = 1'b1;
        if (is_dec) begin
            hv = b - CH_0;
        end else if (b >= CH_A_UP && b <= CH_F_UP) begin
            hv = b - CH_A_UP + 8'd10;
        end else if (b >= CH_A_LO && b <= CH_F_LO) begin
            hv = b - CH_A_LO + 8'd10;
        end else begin
            hv     = 8'h00;
            is_hex = 1'b0;
        end
        again = 1'b1;
        pass  = 0;
        while (again && pass < 2) begin
            again = 1'b0;
            case (ref_mode)
                AT_TEXT: begin
                    if (b == CH_AMP) begin
                        hold_byte(b);
                        ref_mode = AT_AMP;
                    end else if (b != CH_NUL) begin
                        emit_byte(b, 1'b0);
                    end
                end
                AT_AMP: begin
                    if (b == CH_HASH) begin
                        hold_byte(b);
                        ref_mode = AT_DEC_FIRST;
                    end else begin
                        replay_reference();
                        again = 1'b1;
                    end
                end
                AT_DEC_FIRST, AT_DEC: begin
                    if (ref_mode == AT_DEC_FIRST && (b == CH_X_LO || b == CH_X_UP)) begin
                        hold_byte(b);
                        ref_mode = AT_HEX_FIRST;
                    end else if (is_dec) begin
                        again = take_digit(b, hv[3:0], 1'b0, AT_DEC);
                    end else if (b == CH_SEMI && ref_mode == AT_DEC) begin
                        encode_reference();
                    end else begin
                        replay_reference();
                        again = 1'b1;
                    end
                end
                default: begin
                    if (is_hex) begin
                        again = take_digit(b, hv[3:0], 1'b1, AT_HEX);
                    end else if (b == CH_SEMI && ref_mode == AT_HEX) begin
                        encode_reference();
                    end else begin
                        replay_reference();
                        again = 1'b1;
                    end
                end
            endcase
            pass++;
        end
        if (decoded_now.size() > 0) begin
            decoded_now[decoded_now.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void add_row(input logic [7:0] b, input logic typed,
                                    input logic [1:0] n, input logic [7:0] d,
                                    input logic e);
        t_stim_row row;
        row.in_byte    = b;
        row.typed      = typed;
        row.typed_n    = n;
        row.typed_data = d;
        row.typed_err  = e;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Every byte of a reference but the last causes nothing while it is collected.
    function automatic void add_ref(input string s, input logic typed,
                                    input logic [1:0] n, input logic [7:0] d,
                                    input logic e);
        for (int i = 0; i < s.len() - 1; i++) begin
            add_row(s[i], 1'b1, 2'd0, 8'h00, 1'b0);
        end
        add_row(s[s.len() - 1], typed, n, d, e);
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 10) begin
            return CH_0 + {4'd0, d};
        end
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
    endfunction

    function automatic void append_digits(input logic [31:0] value, input logic hex);
        logic [3:0] digs [12];
        int         n;
        n = 0;
        do begin
            digs[n] = hex ? value[3:0] : 4'(value % 10);
            value   = hex ? (value >> 4) : (value / 10);
            n++;
        end while (value != 0);
        for (int i = n - 1; i >= 0; i--) begin
            put_text(digit_char(digs[i]));
        end
    endfunction

    function automatic logic [31:0] pick_code_point();
        int bits;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 7))
                0: return 32'h0;
                1: return 32'h7F;
                2: return 32'h80;
                3: return 32'h7FF;
                4: return 32'h800;
                5: return 32'hFFFF;
                6: return 32'h10000;
                default: return {11'd0, CODE_LIMIT};
            endcase
        end
        bits = $urandom_range(1, 21);
        return $urandom & ((32'd1 << bits) - 1) & 32'h000FFFFF;
    endfunction

    // Appends one run of text: mostly well-formed references with random content,
    // the rest plain bytes, broken or overlong references and named entities.
    function automatic void append_random_run();
        int   kind;
        int   n;
        logic hex;
        kind = $urandom_range(0, 99);
        hex  = $urandom_range(0, 1);
        if (kind < 18) begin
            n = $urandom_range(1, 6);
            repeat (n) put_text(8'($urandom_range(0, 255)));
        end else if (kind < 86) begin
            put_text(CH_AMP);
            put_text(CH_HASH);
            if (hex) begin
                put_text($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            end
            if (kind < 70) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                repeat (n) put_text(CH_0);
                append_digits(pick_code_point(), hex);
            end else if (kind < 78) begin
                // Leading zeros can push the reference past the pending store.
                n = $urandom_range(10, 20);
                repeat (n) put_text(CH_0);
                append_digits($urandom_range(1, 200), hex);
            end else begin
                // Values beyond the last code point.
                put_text(CH_0 + 8'($urandom_range(2, 9)));
                n = $urandom_range(6, 8);
                repeat (n) put_text(digit_char(hex ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 9))));
            end
            put_text(CH_SEMI);
        end else if (kind < 94) begin
            put_text(CH_AMP);
            if ($urandom_range(0, 3) != 0) begin
                put_text(CH_HASH);
                if (hex) begin
                    put_text(CH_X_LO);
                end
                n = $urandom_range(0, 3);
                repeat (n) put_text(digit_char(4'($urandom_range(0, 9))));
            end
            put_text(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
        end else begin
            put_text(CH_AMP);
            put_text(CH_A_LO);
            put_text(8'h6D);
            put_text(8'h70);
            put_text(CH_SEMI);
        end
    endfunction

    // Offers one byte after the given gap and returns at the edge of its transaction.
    task automatic send_item(input logic [7:0] b, input int gap);
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    initial begin
        t_stim_row row;
        t_utf8_out r;
        int        gap;

        // Plain bytes straight after reset, both byte extremes, and an end of text
        // that has nothing to flush.
        add_row(8'h41, 1'b1, 2'd1, 8'h41, 1'b0);
        add_row(8'hFF, 1'b1, 2'd1, 8'hFF, 1'b0);
        add_row(CH_NUL, 1'b1, 2'd0, 8'h00, 1'b0);
        // No digits: replayed, and the semicolon passes through.
        add_ref("&#;", 1'b0, 2'd0, 8'h00, 1'b0);
        // A surrogate is encoded like any other three-byte code point.
        add_ref("&#xD800;", 1'b0, 2'd0, 8'h00, 1'b0);
        // One past the last code point gives a single error result.
        add_ref("&#1114112;", 1'b1, 2'd1, 8'h00, 1'b1);
        // End of text in the middle of a reference flushes it.
        add_ref("&#5", 1'b1, 2'd0, 8'h00, 1'b0);
        add_row(CH_NUL, 1'b0, 2'd0, 8'h00, 1'b0);

        while (text_bytes.size() < RANDOM_ITEMS) begin
            append_random_run();
        end

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.in_byte, $urandom_range(0, 10));
            decode_byte(row.in_byte);
            if (row.typed) begin
                if (row.typed_n != 0) begin
                    r.data  = row.typed_data;
                    r.last  = 1'b1;
                    r.error = row.typed_err;
                    put_due(r);
                end
            end else begin
                foreach (decoded_now[k]) put_due(decoded_now[k]);
            end
        end

        foreach (text_bytes[i]) begin
            // A long hold on the master side while bytes keep coming fills the block.
            if (i == HOLD_FIRST_ITEM) begin
                long_hold_req = 1'b1;
            end
            if ((i >= HOLD_FIRST_ITEM && i < HOLD_LAST_ITEM) || (i / 40) % 3 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 10);
            end
            send_item(text_bytes[i], gap);
            decode_byte(text_bytes[i]);
            foreach (decoded_now[k]) put_due(decoded_now[k]);
        end
        i_s_axis_tvalid <= 1'b0;

        while (decoded_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Master side: random back-pressure per transaction, with quiet stretches and
    // one long hold-off.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if ((results_seen / 60) % 3 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            repeat (stall) begin
                i_m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Checks each output transaction against the oldest expectation and watches
    // for a stalled run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (decoded_due.size() == 0) begin
                    $error("unexpected output transaction: out_byte %h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = decoded_due.pop_front();
                    if (o_m_axis_tdata !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, o_m_axis_tdata);
                        fail_count++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                        fail_count++;
                    end
                    if (o_m_axis_tuser !== want.error) begin
                        $error("error: expected %b, got %b", want.error, o_m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) ||
                (i_s_axis_tvalid && o_s_axis_tready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

FILE: numeric_char_reference_decoder_core.f
rtl/core/ncrd_pkg.sv
rtl/core/ncrd_ctrl.sv
rtl/core/ncrd_dpath.sv
rtl/core/numeric_char_reference_decoder_core.sv
tb/numeric_char_reference_decoder_core_test.sv
